>>> sv/sgds_pkg.sv
// Shared types and constants for the spark-gap discharge statistics block.
// No dependencies; imported by every module of the block.
package sgds_pkg;

  localparam int unsigned GAP_W    = 24;
  localparam int unsigned VEL_W    = 16;
  localparam int unsigned WIN_W    = 32;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned DELAY_W  = 15;
  localparam int unsigned MODE_W   = 8;
  localparam int unsigned RATIO_W  = 18;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned QDEPTH   = 2;
  localparam int unsigned QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [GAP_W-1:0]   GAP_MAX   = 24'hFFFFFF;
  localparam logic [RATIO_W-1:0] RATIO_ONE = 18'd65536;
  localparam logic [RATIO_W-1:0] RATIO_MAX = 18'd196608;

  localparam logic [CFG_IDX_W-1:0] CFG_COUPLING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDEAL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd3;

  localparam int unsigned TDATA_W = 80;
  localparam int unsigned TUSER_W = 9;

  typedef struct packed {
    logic [WIN_W-1:0]        win_seq;
    logic signed [VEL_W-1:0] feed_velocity;
    logic                    run_state;
  } sgds_item_t;

  typedef struct packed {
    logic [WIN_W-1:0]   win_seq;
    logic [PCT_W-1:0]   normal_pct;
    logic [PCT_W-1:0]   arc_pct;
    logic [PCT_W-1:0]   short_pct;
    logic [PCT_W-1:0]   open_pct;
    logic [DELAY_W-1:0] ignition_delay_ns;
    logic               run_state;
    logic [MODE_W-1:0]  active_mode;
  } sgds_result_t;

endpackage

>>> sv/sgds_front.sv
// Front end: accepts ticks, stamps the window number and decodes the run state,
// then queues them for the back end. Depends on sgds_pkg.
module sgds_front import sgds_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [VEL_W-1:0] in_velocity_i,
  input  logic                    in_cutting_i,
  output logic                    item_valid_o,
  input  logic                    item_ready_i,
  output sgds_item_t              item_o
);

  sgds_item_t          queue_q [QDEPTH];
  logic [QPTR_W-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic [WIN_W-1:0]    win_q, win_d;
  logic                push, pop;

  assign in_ready_o   = (cnt_q != QCNT_W'(QDEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = queue_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    win_d  = win_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      win_d  = win_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
      win_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
      win_q  <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wptr_q] <= '{win_seq: win_q, feed_velocity: in_velocity_i,
                           run_state: !in_cutting_i};
    end
  end

endmodule

>>> sv/sgds_back.sv
// Back end: configuration registers, gap update, iterative ratio divider,
// discharge percentages and the output register. Depends on sgds_pkg.
module sgds_back import sgds_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [GAP_W-1:0]      cfg_data_i,
  input  logic                  item_valid_i,
  output logic                  item_ready_o,
  input  sgds_item_t            item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sgds_result_t          out_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_GAP  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_PCT  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [4:0] DIV_LAST = 5'(RATIO_W - 1);

  logic [2:0]          state_q, state_d;
  logic [GAP_W-1:0]    gain_q, ideal_q, gap_q;
  logic [MODE_W-1:0]   mode_q;
  sgds_item_t          item_q;
  logic signed [40:0]  prod_q;
  logic [RATIO_W-1:0]  ratio_q;
  logic [GAP_W-1:0]    rem_q;
  logic [4:0]          cnt_q;
  logic [PCT_W-1:0]    short_q, arc_q, open_q;
  logic [DELAY_W-1:0]  delay_q;
  logic                out_valid_q;
  sgds_result_t        out_q;

  logic signed [41:0]  g_full;
  logic [41:0]         g_round;
  logic [24:0]         g_shift;
  logic [GAP_W-1:0]    gap_new;
  logic [25:0]         gap_x4;
  logic                div_bit;
  logic [24:0]         trial;
  logic                trial_ge;
  logic [RATIO_W-1:0]  r_sat;
  logic [24:0]         r25;
  logic [24:0]         s_lo, a_lo, o_lo, s_hi, a_hi, o_hi;
  logic [24:0]         d25;
  logic [31:0]         dly_prod;
  logic [8:0]          pct_sum;
  logic [PCT_W-1:0]    normal;
  logic                out_load;

  assign item_ready_o = (state_q == S_IDLE);
  assign out_load     = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // gap update
  assign g_full  = $signed({2'b00, gap_q, 16'h0000}) - 42'(prod_q);
  assign g_round = 42'(g_full) + 42'd32768;
  assign g_shift = g_round[40:16];
  always_comb begin
    if (g_full[41]) begin
      gap_new = '0;
    end else if (g_shift > 25'(GAP_MAX)) begin
      gap_new = GAP_MAX;
    end else begin
      gap_new = g_shift[GAP_W-1:0];
    end
  end
  assign gap_x4 = {ideal_q, 2'b00};

  // restoring division, one quotient bit a cycle
  always_comb begin
    if (cnt_q == DIV_LAST) begin
      div_bit = gap_q[1];
    end else if (cnt_q == DIV_LAST - 5'd1) begin
      div_bit = gap_q[0];
    end else begin
      div_bit = 1'b0;
    end
  end
  assign trial    = {rem_q, div_bit};
  assign trial_ge = (trial >= {1'b0, ideal_q});

  // percentages
  assign r_sat = (ratio_q > RATIO_MAX) ? RATIO_MAX : ratio_q;
  assign r25   = 25'(r_sat);
  assign d25   = r25 - 25'(RATIO_ONE);
  assign s_lo  = 25'(90 * 65536 + 32768) - 25'd84 * r25;
  assign a_lo  = 25'(5 * 65536 + 32768) + 25'd3 * r25;
  assign o_lo  = 25'd32768 + 25'd6 * r25;
  assign s_hi  = 25'(6 * 131072 + 65536) - 25'd6 * d25;
  assign a_hi  = 25'(8 * 131072 + 65536) - 25'd3 * d25;
  assign o_hi  = 25'(6 * 131072 + 65536) + 25'd74 * d25;
  assign dly_prod = 32'(r_sat) * 32'd8000;

  assign pct_sum = 9'(short_q) + 9'(arc_q) + 9'(open_q);
  assign normal  = (pct_sum > 9'd100) ? '0 : PCT_W'(9'd100 - pct_sum);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (item_valid_i) state_d = S_MUL;
      S_MUL:  state_d = S_GAP;
      S_GAP: begin
        if (ideal_q == '0 || {2'b00, gap_new} >= gap_x4) begin
          state_d = S_PCT;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV:  if (cnt_q == '0) state_d = S_PCT;
      S_PCT:  state_d = S_OUT;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gain_q      <= '0;
      ideal_q     <= '0;
      gap_q       <= '0;
      mode_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_COUPLING: gain_q  <= cfg_data_i;
          CFG_IDEAL:    ideal_q <= cfg_data_i;
          CFG_START:    gap_q   <= cfg_data_i;
          CFG_MODE:     mode_q  <= cfg_data_i[MODE_W-1:0];
        endcase
      end else if (state_q == S_GAP) begin
        gap_q <= gap_new;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (item_valid_i) item_q <= item_i;
      S_MUL:  prod_q <= $signed({1'b0, gain_q}) * $signed(item_q.feed_velocity);
      S_GAP: begin
        cnt_q <= DIV_LAST;
        rem_q <= GAP_W'(gap_new[GAP_W-1:2]);
        if (ideal_q == '0) begin
          ratio_q <= '0;
        end else if ({2'b00, gap_new} >= gap_x4) begin
          ratio_q <= RATIO_MAX;
        end else begin
          ratio_q <= '0;
        end
      end
      S_DIV: begin
        cnt_q   <= cnt_q - 5'd1;
        ratio_q <= {ratio_q[RATIO_W-2:0], trial_ge};
        rem_q   <= trial_ge ? GAP_W'(trial - {1'b0, ideal_q}) : trial[GAP_W-1:0];
      end
      S_PCT: begin
        if (r_sat <= RATIO_ONE) begin
          short_q <= s_lo[22:16];
          arc_q   <= a_lo[22:16];
          open_q  <= o_lo[22:16];
        end else begin
          short_q <= s_hi[23:17];
          arc_q   <= a_hi[23:17];
          open_q  <= o_hi[23:17];
        end
        delay_q <= DELAY_W'(2000) + dly_prod[30:16];
      end
      S_OUT: begin
        if (out_load) begin
          out_q <= '{win_seq: item_q.win_seq, normal_pct: normal,
                     arc_pct: arc_q, short_pct: short_q, open_pct: open_q,
                     ignition_delay_ns: delay_q, run_state: item_q.run_state,
                     active_mode: mode_q};
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_div_needs_ideal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> ideal_q != '0)
    else $error("divider running with zero ideal gap");

  a_load_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("result raised outside the output state");

  a_pct_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (8'(out_q.normal_pct) + 8'(out_q.arc_pct) + 8'(out_q.short_pct)
                     + 8'(out_q.open_pct)) == 8'd100)
    else $error("percentages do not add up to one hundred");

  a_delay_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.ignition_delay_ns >= DELAY_W'(2000)
                 && out_q.ignition_delay_ns <= DELAY_W'(26000))
    else $error("ignition delay out of range");

endmodule

>>> sv/spark_gap_discharge_stats_model.sv
// Spark-gap discharge statistics, top level: front queue plus back datapath.
// Path: the front end queues ticks; the back end steps through capture, multiply,
// gap update, ratio divider, percentages and output, and skips the divider when the
// ideal gap is zero or the updated gap is at least four times the ideal gap.
// The back end works one tick at a time and takes the next only after loading the result.
// Reset: async active low; state, configuration, gap and window counter clear to zero.
module spark_gap_discharge_stats_model import sgds_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,   // feed_velocity[15:0]
  input  logic [0:0]            s_axis_tuser,   // cutting_on[0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata,   // win_seq, normal, arc, short,
                                                // open, ignition_delay_ns, zero pad
  output logic [TUSER_W-1:0]    m_axis_tuser,   // run_state[0], active_mode[8:1]
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [GAP_W-1:0]      cfg_data_i
);

  logic         item_valid, item_ready;
  sgds_item_t   item;
  sgds_result_t res;

  sgds_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_velocity_i ($signed(s_axis_tdata)),
    .in_cutting_i  (s_axis_tuser[0]),
    .item_valid_o  (item_valid),
    .item_ready_i  (item_ready),
    .item_o        (item)
  );

  sgds_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (res)
  );

  assign m_axis_tdata = {5'b00000, res.ignition_delay_ns, res.open_pct, res.short_pct,
                         res.arc_pct, res.normal_pct, res.win_seq};
  assign m_axis_tuser = {res.active_mode, res.run_state};

endmodule
